// ----- rtl/odce_pkg.sv -----
// ----------------------------------------------------------------------------
// odce_pkg
// Shared types and constants of the OFDM DPA channel estimator.
// ----------------------------------------------------------------------------
package odce_pkg;

   localparam int SAMPLE_BITS     = 16;
   localparam int FRAC_BITS       = 12;
   localparam int NUM_SUBCARRIERS = 52;
   localparam int SC_BITS         = 6;
   localparam int ADDR_BITS       = $clog2(NUM_SUBCARRIERS);
   localparam int DEC_BITS        = 3;

   localparam logic [SC_BITS-1:0] PILOT_A = SC_BITS'(6);
   localparam logic [SC_BITS-1:0] PILOT_B = SC_BITS'(20);
   localparam logic [SC_BITS-1:0] PILOT_C = SC_BITS'(31);
   localparam logic [SC_BITS-1:0] PILOT_D = SC_BITS'(45);

   localparam logic signed [SAMPLE_BITS-1:0] SCALE_R =
      SAMPLE_BITS'(((707 << FRAC_BITS) + 500) / 1000);

   localparam logic [DEC_BITS-1:0] DEC_PP  = 3'd0;
   localparam logic [DEC_BITS-1:0] DEC_PM  = 3'd1;
   localparam logic [DEC_BITS-1:0] DEC_MP  = 3'd2;
   localparam logic [DEC_BITS-1:0] DEC_MM  = 3'd3;
   localparam logic [DEC_BITS-1:0] DEC_PLP = 3'd4;
   localparam logic [DEC_BITS-1:0] DEC_PLM = 3'd5;

   // divider pipeline: products, sums, one stage per quotient bit, saturation
   localparam int CDIV_LAT  = SAMPLE_BITS + 3;
   localparam int PIPE_LAST = 2 * CDIV_LAT - 1;

   typedef struct packed {
      logic [SC_BITS-1:0]            subcarrier;
      logic signed [SAMPLE_BITS-1:0] rx_re;
      logic signed [SAMPLE_BITS-1:0] rx_im;
      logic signed [SAMPLE_BITS-1:0] chan_re;
      logic signed [SAMPLE_BITS-1:0] chan_im;
      logic signed [SAMPLE_BITS-1:0] ls_re;
      logic signed [SAMPLE_BITS-1:0] ls_im;
      logic                          first_symbol;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] eq_re;
      logic signed [SAMPLE_BITS-1:0] eq_im;
      logic [DEC_BITS-1:0]           decision;
      logic signed [SAMPLE_BITS-1:0] dpa_re;
      logic signed [SAMPLE_BITS-1:0] dpa_im;
      logic signed [SAMPLE_BITS-1:0] avg_re;
      logic signed [SAMPLE_BITS-1:0] avg_im;
      logic                          div_fault;
   } rsp_type;

   typedef struct packed {
      logic [SC_BITS-1:0]            subcarrier;
      logic signed [SAMPLE_BITS-1:0] rx_re;
      logic signed [SAMPLE_BITS-1:0] rx_im;
      logic signed [SAMPLE_BITS-1:0] ls_re;
      logic signed [SAMPLE_BITS-1:0] ls_im;
      logic                          first_symbol;
      logic                          pilot;
      logic                          in_range;
      logic signed [SAMPLE_BITS-1:0] eq_re;
      logic signed [SAMPLE_BITS-1:0] eq_im;
      logic [DEC_BITS-1:0]           decision;
      logic                          fault;
   } ctx_type;

endpackage

// ----- rtl/odce_ram.sv -----
// ----------------------------------------------------------------------------
// odce_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module odce_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 52
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/odce_cdiv.sv -----
// ----------------------------------------------------------------------------
// odce_cdiv
// Pipelined saturating complex divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module odce_cdiv (
   input  logic                                     clock,
   input  logic                                     en,
   input  logic signed [odce_pkg::SAMPLE_BITS-1:0]  a_re,
   input  logic signed [odce_pkg::SAMPLE_BITS-1:0]  a_im,
   input  logic signed [odce_pkg::SAMPLE_BITS-1:0]  b_re,
   input  logic signed [odce_pkg::SAMPLE_BITS-1:0]  b_im,
   output logic signed [odce_pkg::SAMPLE_BITS-1:0]  q_re,
   output logic signed [odce_pkg::SAMPLE_BITS-1:0]  q_im,
   output logic                                     zero
);

   localparam int SB = odce_pkg::SAMPLE_BITS;
   localparam int FB = odce_pkg::FRAC_BITS;
   localparam int PW = 2 * SB;
   localparam int NW = PW + 1;
   localparam int RW = PW + SB;

   logic signed [PW-1:0] p_rr_ff, p_ii_ff, p_ir_ff, p_ri_ff, p_br_ff, p_bi_ff;

   logic signed [NW-1:0] num_re, num_im;
   logic [PW-1:0]        den;

   logic [RW-1:0] rem_re_ff [SB+1];
   logic [RW-1:0] rem_im_ff [SB+1];
   logic [SB-1:0] q_re_ff   [SB+1];
   logic [SB-1:0] q_im_ff   [SB+1];
   logic          neg_re_ff [SB+1];
   logic          neg_im_ff [SB+1];
   logic          ovf_re_ff [SB+1];
   logic          ovf_im_ff [SB+1];
   logic [PW-1:0] den_ff    [SB+1];

   logic signed [SB-1:0] q_re_in, q_im_in;
   logic signed [SB-1:0] q_re_out_ff, q_im_out_ff;
   logic                 zero_ff;

   function automatic logic signed [SB-1:0] sat_q(input logic [SB-1:0] q,
                                                  input logic ovf, input logic neg);
      logic [SB-1:0] lim;
      logic [SB-1:0] m;
      lim = neg ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}};
      m   = (ovf || (q > lim)) ? lim : q;
      return neg ? -$signed(m) : $signed(m);
   endfunction

   always_comb begin
      num_re = NW'(p_rr_ff) + NW'(p_ii_ff);
      num_im = NW'(p_ir_ff) - NW'(p_ri_ff);
      den    = PW'($unsigned(p_br_ff)) + PW'($unsigned(p_bi_ff));
      q_re_in = sat_q(q_re_ff[SB], ovf_re_ff[SB], neg_re_ff[SB]);
      q_im_in = sat_q(q_im_ff[SB], ovf_im_ff[SB], neg_im_ff[SB]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_rr_ff <= a_re * b_re;
         p_ii_ff <= a_im * b_im;
         p_ir_ff <= a_im * b_re;
         p_ri_ff <= a_re * b_im;
         p_br_ff <= b_re * b_re;
         p_bi_ff <= b_im * b_im;

         neg_re_ff[0] <= num_re[NW-1];
         neg_im_ff[0] <= num_im[NW-1];
         rem_re_ff[0] <= RW'({PW'(num_re[NW-1] ? -num_re : num_re), {FB{1'b0}}});
         rem_im_ff[0] <= RW'({PW'(num_im[NW-1] ? -num_im : num_im), {FB{1'b0}}});
         q_re_ff[0]   <= '0;
         q_im_ff[0]   <= '0;
         ovf_re_ff[0] <= 1'b0;
         ovf_im_ff[0] <= 1'b0;
         den_ff[0]    <= den;

         for (int j = 0; j < SB; j++) begin
            neg_re_ff[j+1] <= neg_re_ff[j];
            neg_im_ff[j+1] <= neg_im_ff[j];
            den_ff[j+1]    <= den_ff[j];
            if (j == 0) begin
               ovf_re_ff[j+1] <= rem_re_ff[j] >= (RW'(den_ff[j]) << SB);
               ovf_im_ff[j+1] <= rem_im_ff[j] >= (RW'(den_ff[j]) << SB);
            end else begin
               ovf_re_ff[j+1] <= ovf_re_ff[j];
               ovf_im_ff[j+1] <= ovf_im_ff[j];
            end
            if (rem_re_ff[j] >= (RW'(den_ff[j]) << (SB - 1 - j))) begin
               rem_re_ff[j+1] <= rem_re_ff[j] - (RW'(den_ff[j]) << (SB - 1 - j));
               q_re_ff[j+1]   <= q_re_ff[j] | (SB'(1) << (SB - 1 - j));
            end else begin
               rem_re_ff[j+1] <= rem_re_ff[j];
               q_re_ff[j+1]   <= q_re_ff[j];
            end
            if (rem_im_ff[j] >= (RW'(den_ff[j]) << (SB - 1 - j))) begin
               rem_im_ff[j+1] <= rem_im_ff[j] - (RW'(den_ff[j]) << (SB - 1 - j));
               q_im_ff[j+1]   <= q_im_ff[j] | (SB'(1) << (SB - 1 - j));
            end else begin
               rem_im_ff[j+1] <= rem_im_ff[j];
               q_im_ff[j+1]   <= q_im_ff[j];
            end
         end

         zero_ff     <= (den_ff[SB] == '0);
         q_re_out_ff <= (den_ff[SB] == '0) ? '0 : q_re_in;
         q_im_out_ff <= (den_ff[SB] == '0) ? '0 : q_im_in;
      end
   end

   assign q_re = q_re_out_ff;
   assign q_im = q_im_out_ff;
   assign zero = zero_ff;

endmodule

// ----- rtl/ofdm_dpa_channel_estimator_unit.sv -----
// ----------------------------------------------------------------------------
// ofdm_dpa_channel_estimator_unit
// Per-subcarrier equalization, QPSK decision and DPA channel estimate
// averaged against a per-subcarrier estimate store.
// ----------------------------------------------------------------------------
//  port group  | dir | handshake          | payload
//  req_*       | in  | req_valid/ready    | odce_pkg::req_type
//  rsp_*       | out | rsp_valid/ready    | odce_pkg::rsp_type
//
//  One transfer per cycle in and out while no result is held; the pipeline
//  depth is set by two chained bit-per-stage complex dividers.
//  The store is read in the cycle before the averaging stage and written back
//  from it; a same-subcarrier neighbor is forwarded.
//  A held result stalls the whole pipeline. Reset clears only the valid bits and the forward flag.
// ----------------------------------------------------------------------------
module ofdm_dpa_channel_estimator_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  odce_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output odce_pkg::rsp_type rsp_data
);

   localparam int SB   = odce_pkg::SAMPLE_BITS;
   localparam int LAT  = odce_pkg::CDIV_LAT;
   localparam int LAST = odce_pkg::PIPE_LAST;
   localparam int AW   = odce_pkg::ADDR_BITS;

   logic                en;
   odce_pkg::ctx_type   line_ff [LAST+1];
   logic                vld_ff  [LAST+1];
   odce_pkg::ctx_type   in_ctx, mid_ctx, cur, fin;
   logic signed [SB-1:0] c1_re, c1_im, c2_re, c2_im, ref_re, ref_im;
   logic                c1_zero, c2_zero;
   logic signed [SB-1:0] prev_re, prev_im;
   logic signed [SB:0]  sum_re, sum_im;
   logic [2*SB-1:0]     ram_q, fwd_data_ff, wr_data;
   logic                fwd_ff, fwd_in, wr_en;
   logic [AW-1:0]       rd_addr, wr_addr;
   logic                rsp_valid_ff;
   odce_pkg::rsp_type   rsp_ff, rsp_in;

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   always_comb begin
      in_ctx              = '0;
      in_ctx.subcarrier   = req_data.subcarrier;
      in_ctx.rx_re        = req_data.rx_re;
      in_ctx.rx_im        = req_data.rx_im;
      in_ctx.ls_re        = req_data.ls_re;
      in_ctx.ls_im        = req_data.ls_im;
      in_ctx.first_symbol = req_data.first_symbol;
      in_ctx.in_range     = req_data.subcarrier < odce_pkg::SC_BITS'(odce_pkg::NUM_SUBCARRIERS);
      in_ctx.pilot        = in_ctx.in_range &&
                            (req_data.subcarrier == odce_pkg::PILOT_A ||
                             req_data.subcarrier == odce_pkg::PILOT_B ||
                             req_data.subcarrier == odce_pkg::PILOT_C ||
                             req_data.subcarrier == odce_pkg::PILOT_D);
   end

   odce_cdiv u_eq_div (
      .clock (clock),
      .en    (en),
      .a_re  (req_data.rx_re),
      .a_im  (req_data.rx_im),
      .b_re  (req_data.chan_re),
      .b_im  (req_data.chan_im),
      .q_re  (c1_re),
      .q_im  (c1_im),
      .zero  (c1_zero)
   );

   always_comb begin
      cur     = line_ff[LAT-1];
      mid_ctx = cur;
      if (cur.pilot) begin
         mid_ctx.eq_re = '0;
         mid_ctx.eq_im = '0;
         mid_ctx.fault = 1'b0;
         if (cur.subcarrier == odce_pkg::PILOT_D) begin
            mid_ctx.decision = odce_pkg::DEC_PLM;
            ref_re = -odce_pkg::SCALE_R;
         end else begin
            mid_ctx.decision = odce_pkg::DEC_PLP;
            ref_re = odce_pkg::SCALE_R;
         end
         ref_im = '0;
      end else begin
         mid_ctx.eq_re = c1_re;
         mid_ctx.eq_im = c1_im;
         mid_ctx.fault = c1_zero;
         unique case ({c1_re[SB-1], c1_im[SB-1]})
            2'b00:   mid_ctx.decision = odce_pkg::DEC_PP;
            2'b01:   mid_ctx.decision = odce_pkg::DEC_PM;
            2'b10:   mid_ctx.decision = odce_pkg::DEC_MP;
            default: mid_ctx.decision = odce_pkg::DEC_MM;
         endcase
         ref_re = c1_re[SB-1] ? -odce_pkg::SCALE_R : odce_pkg::SCALE_R;
         ref_im = c1_im[SB-1] ? -odce_pkg::SCALE_R : odce_pkg::SCALE_R;
      end
   end

   odce_cdiv u_dpa_div (
      .clock (clock),
      .en    (en),
      .a_re  (cur.rx_re),
      .a_im  (cur.rx_im),
      .b_re  (ref_re),
      .b_im  (ref_im),
      .q_re  (c2_re),
      .q_im  (c2_im),
      .zero  (c2_zero)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         line_ff[0] <= in_ctx;
         for (int i = 1; i <= LAST; i++) begin
            if (i != LAT) begin
               line_ff[i] <= line_ff[i-1];
            end
         end
         line_ff[LAT] <= mid_ctx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= LAST; i++) begin
            vld_ff[i] <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= req_valid;
         for (int i = 1; i <= LAST; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
         rsp_valid_ff <= vld_ff[LAST];
      end
   end

   // store access: read for the item entering the last stage
   assign fin     = line_ff[LAST];
   assign rd_addr = line_ff[LAST-1].in_range ? AW'(line_ff[LAST-1].subcarrier) : '0;
   assign wr_addr = AW'(fin.subcarrier);
   assign wr_en   = en && vld_ff[LAST] && fin.in_range;
   assign fwd_in  = vld_ff[LAST] && fin.in_range &&
                    (line_ff[LAST-1].subcarrier == fin.subcarrier);

   odce_ram #(
      .WIDTH (2 * SB),
      .DEPTH (odce_pkg::NUM_SUBCARRIERS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (en),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   always_comb begin
      priority if (fin.first_symbol) begin
         prev_re = fin.ls_re;
         prev_im = fin.ls_im;
      end else if (!fin.in_range) begin
         prev_re = '0;
         prev_im = '0;
      end else if (fwd_ff) begin
         prev_re = fwd_data_ff[2*SB-1:SB];
         prev_im = fwd_data_ff[SB-1:0];
      end else begin
         prev_re = ram_q[2*SB-1:SB];
         prev_im = ram_q[SB-1:0];
      end
      sum_re = (SB+1)'(c2_re) + (SB+1)'(prev_re);
      sum_im = (SB+1)'(c2_im) + (SB+1)'(prev_im);

      rsp_in.eq_re     = fin.eq_re;
      rsp_in.eq_im     = fin.eq_im;
      rsp_in.decision  = fin.decision;
      rsp_in.dpa_re    = c2_re;
      rsp_in.dpa_im    = c2_im;
      rsp_in.avg_re    = sum_re[SB:1];
      rsp_in.avg_im    = sum_im[SB:1];
      rsp_in.div_fault = fin.fault || c2_zero;
      wr_data          = {rsp_in.avg_re, rsp_in.avg_im};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else if (en) begin
         fwd_ff <= fwd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fwd_data_ff <= wr_data;
         rsp_ff      <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- rtl/odce_checker.sv -----
// ----------------------------------------------------------------------------
// odce_checker
// Port-level checks of the estimator, bound to the top level.
// ----------------------------------------------------------------------------
module odce_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input odce_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input odce_pkg::rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped before transfer");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without a held result");

   a_pilot_eq: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.decision == odce_pkg::DEC_PLP ||
                    rsp_data.decision == odce_pkg::DEC_PLM)
      |-> rsp_data.eq_re == '0 && rsp_data.eq_im == '0)
      else $error("pilot result with nonzero equalized sample");

   a_fault_eq: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.div_fault
      |-> rsp_data.eq_re == '0 && rsp_data.eq_im == '0 &&
          rsp_data.decision == odce_pkg::DEC_PP)
      else $error("zero channel result not forced to zero");

endmodule

bind ofdm_dpa_channel_estimator_unit odce_checker u_odce_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
